// ===== sv/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

    // Queue geometry
    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    // Action codes carried by a request
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_CLEAR      = 3'd4,
        ACT_PEEK       = 3'd5
    } action_t;

    // Status codes reported with each result
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One write into the slot store
    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       addr;
        logic [VALUE_WIDTH-1:0] data;
    } wr_req_t;

    // The two slots read for a result
    typedef struct packed {
        logic [IDX_W-1:0] front_addr;
        logic [IDX_W-1:0] back_addr;
    } rd_req_t;

endpackage

// ===== sv/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// request   in         start, busy          action, push_value
// result    out        done (one cycle)     front_value, back_value, item_count,
//                                           is_empty, status
//
// A request is taken when start is high and busy is low. Its result appears on
// the result ports in the following cycle, with done high for that one cycle.
// Busy is high during that result cycle, so a new request is not taken until the
// last result has been shown; this follows from the registered read of the slot store.
// Reset clears the front index and the count; slot contents are not cleared.
// The receiver cannot stall: each result is taken in the cycle it is shown.

module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         action,
    input  logic signed [31:0] push_value,
    output logic               done,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic [4:0]         item_count,
    output logic               is_empty,
    output logic [1:0]         status
);

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             resp_reg;
    logic             empty_reg;
    status_t          status_reg, status_next;

    logic [IDX_W-1:0] front_dec, front_inc, tail_addr;
    logic [SUM_W-1:0] tail_sum, back_sum;
    logic             full, empty, accept;
    wr_req_t          wr;
    rd_req_t          rd;
    logic signed [VALUE_WIDTH-1:0] front_data, back_data;

    assign accept = start && !resp_reg;
    assign full   = (count_reg >= CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    // Ring pointer arithmetic
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign tail_addr = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(tail_sum);

    // Action decode: next pointers, store write and status
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        wr.en       = 1'b0;
        wr.addr     = tail_addr;
        wr.data     = VALUE_WIDTH'($unsigned(push_value));
        unique case (action_t'(action))
            ACT_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                    wr.en      = accept;
                    wr.addr    = front_dec;
                end
            end
            ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    wr.en      = accept;
                end
            end
            ACT_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            ACT_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
            end
            default:
            begin
                // unused codes leave the queue as it is
            end
        endcase
    end

    // Read addresses of the new front and back slots
    assign back_sum = SUM_W'(front_next) + SUM_W'(count_next) - 1'b1;
    always_comb
    begin
        rd.front_addr = front_next;
        if (count_next == '0)
        begin
            rd.back_addr = front_next;
        end
        else if (back_sum >= SUM_W'(DEPTH))
        begin
            rd.back_addr = IDX_W'(back_sum - SUM_W'(DEPTH));
        end
        else
        begin
            rd.back_addr = IDX_W'(back_sum);
        end
    end

    deq_store u_store (
        .clk        (clk),
        .wr         (wr),
        .rd         (rd),
        .front_data (front_data),
        .back_data  (back_data)
    );

    // Pointer, count and result state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            resp_reg   <= 1'b0;
            empty_reg  <= 1'b1;
            status_reg <= ST_DONE;
        end
        else
        begin
            resp_reg <= accept;
            if (accept)
            begin
                front_reg  <= front_next;
                count_reg  <= count_next;
                empty_reg  <= (count_next == '0);
                status_reg <= status_next;
            end
        end
    end

    // Result ports
    assign busy        = resp_reg;
    assign done        = resp_reg;
    assign front_value = empty_reg ? '0 : 32'(front_data);
    assign back_value  = empty_reg ? '0 : 32'(back_data);
    assign item_count  = 5'(count_reg);
    assign is_empty    = empty_reg;
    assign status      = status_reg;

    // Checks
    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without a request");

    a_request_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && done))
        else $error("request not answered in the next cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status_reg == ST_FULL)) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("push refused while not full");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (empty_reg == (count_reg == '0)))
        else $error("empty flag disagrees with count");

endmodule

// ===== sv/deq_store.sv =====
`timescale 1ns / 1ps

module deq_store
    import deq_pkg::*;
(
    input  logic                   clk,
    input  wr_req_t                wr,
    input  rd_req_t                rd,
    output logic [VALUE_WIDTH-1:0] front_data,
    output logic [VALUE_WIDTH-1:0] back_data
);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Two registered read ports; a write to the same slot in the same cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd.front_addr))
        begin
            front_data <= wr.data;
        end
        else
        begin
            front_data <= mem[rd.front_addr];
        end
        if (wr.en && (wr.addr == rd.back_addr))
        begin
            back_data <= wr.data;
        end
        else
        begin
            back_data <= mem[rd.back_addr];
        end
    end

endmodule

// ===== tb/double_ended_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;
    import deq_pkg::*;

    // Codes outside the action set; the block treats them as no operation
    localparam logic [2:0] ACT_NOP_6 = 3'd6;
    localparam logic [2:0] ACT_NOP_7 = 3'd7;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    localparam int RANDOM_ITEMS = 1890;
    localparam int PHASE_ITEMS  = 630;
    localparam int IDLE_PCT [3] = '{0, 74, 31};
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;

    // What one result shows of the queue
    typedef struct packed {
        logic signed [31:0] front;
        logic signed [31:0] back;
        logic [4:0]         count;
        logic               empty;
        status_t            st;
    } deq_view_t;

    localparam deq_view_t VIEW_EMPTY_REFUSED = '{32'sd0, 32'sd0, 5'd0, 1'b1, ST_EMPTY};
    localparam deq_view_t VIEW_EMPTY_DONE    = '{32'sd0, 32'sd0, 5'd0, 1'b1, ST_DONE};

    // One row of the directed table; rep issues the row with val, val+1, ...
    typedef struct {
        logic [2:0]         act;
        logic signed [31:0] val;
        int                 rep;
        bit                 typed;
        deq_view_t          exp;
    } stim_row_t;

    stim_row_t directed_rows [0:15] = '{
        '{ACT_POP_FRONT,  32'sd0,          1, 1'b1, VIEW_EMPTY_REFUSED},
        '{ACT_POP_BACK,   32'sd0,          1, 1'b1, VIEW_EMPTY_REFUSED},
        '{ACT_PEEK,       32'sd0,          1, 1'b1, VIEW_EMPTY_REFUSED},
        '{ACT_NOP_6,      32'sd0,          1, 1'b1, VIEW_EMPTY_DONE},
        '{ACT_PUSH_BACK,  VAL_MAX,         1, 1'b1, '{VAL_MAX, VAL_MAX, 5'd1, 1'b0, ST_DONE}},
        '{ACT_PUSH_FRONT, VAL_MIN,         1, 1'b1, '{VAL_MIN, VAL_MAX, 5'd2, 1'b0, ST_DONE}},
        '{ACT_POP_BACK,   32'sd0,          1, 1'b1, '{VAL_MIN, VAL_MIN, 5'd1, 1'b0, ST_DONE}},
        '{ACT_PUSH_BACK,  32'sh1234_5678,  8, 1'b0, '0},
        '{ACT_PUSH_FRONT, 32'sh5A5A_0000,  7, 1'b0, '0},
        '{ACT_PUSH_BACK,  32'shDEAD_BEEF,  1, 1'b0, '0},
        '{ACT_PUSH_FRONT, 32'sd0,          1, 1'b0, '0},
        '{ACT_NOP_7,      32'sd0,          1, 1'b0, '0},
        '{ACT_PEEK,       32'sd0,          1, 1'b0, '0},
        '{ACT_POP_FRONT,  32'sd0,          1, 1'b0, '0},
        '{ACT_CLEAR,      32'sd0,          1, 1'b1, VIEW_EMPTY_DONE},
        '{ACT_CLEAR,      32'sd0,          1, 1'b1, VIEW_EMPTY_DONE}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         action;
    logic signed [31:0] push_value;
    logic               done;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         item_count;
    logic               is_empty;
    logic [1:0]         status;

    // Side info travelling with each request
    logic               row_is_typed;
    deq_view_t          row_view;

    // Mirror of the queue
    logic signed [VALUE_WIDTH-1:0] slot_mirror [DEPTH];
    int                            head_idx;
    int                            fill_count;

    deq_view_t awaited_views [$];
    int        view_errors;
    int        stall_cycles;

    double_ended_queue_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .push_value  (push_value),
        .done        (done),
        .front_value (front_value),
        .back_value  (back_value),
        .item_count  (item_count),
        .is_empty    (is_empty),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one action to the mirror and return the view it leaves
    function automatic deq_view_t apply_action(logic [2:0] act, logic signed [31:0] val);
        deq_view_t v;
        v.st = ST_DONE;
        case (act)
            ACT_PUSH_FRONT:
                if (fill_count >= DEPTH)
                    v.st = ST_FULL;
                else
                begin
                    head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    slot_mirror[head_idx] = VALUE_WIDTH'(val);
                    fill_count++;
                end
            ACT_PUSH_BACK:
                if (fill_count >= DEPTH)
                    v.st = ST_FULL;
                else
                begin
                    slot_mirror[(head_idx + fill_count) % DEPTH] = VALUE_WIDTH'(val);
                    fill_count++;
                end
            ACT_POP_FRONT:
                if (fill_count == 0)
                    v.st = ST_EMPTY;
                else
                begin
                    head_idx = (head_idx + 1) % DEPTH;
                    fill_count--;
                end
            ACT_POP_BACK:
                if (fill_count == 0)
                    v.st = ST_EMPTY;
                else
                    fill_count--;
            ACT_CLEAR:
            begin
                head_idx   = 0;
                fill_count = 0;
            end
            ACT_PEEK:
                if (fill_count == 0)
                    v.st = ST_EMPTY;
            default: ;
        endcase
        // Only occupied slots are read
        if (fill_count == 0)
        begin
            v.front = '0;
            v.back  = '0;
        end
        else
        begin
            v.front = slot_mirror[head_idx];
            v.back  = slot_mirror[(head_idx + fill_count - 1) % DEPTH];
        end
        v.count = 5'(fill_count);
        v.empty = (fill_count == 0);
        return v;
    endfunction

    task automatic log_mismatch(input deq_view_t want, input deq_view_t got, input bit orphan);
        if (view_errors < 10)
        begin
            if (orphan)
                $display({"result with no request outstanding: ",
                          "front=%0d back=%0d count=%0d empty=%0b status=%0d"},
                         got.front, got.back, got.count, got.empty, got.st);
            else
                $display("mismatch: want front=%0d back=%0d count=%0d empty=%0b status=%0d",
                         want.front, want.back, want.count, want.empty, want.st);
            if (!orphan)
                $display("          got  front=%0d back=%0d count=%0d empty=%0b status=%0d",
                         got.front, got.back, got.count, got.empty, got.st);
        end
        view_errors++;
    endtask

    // Result check, request capture and stall counting
    always @(posedge clk)
    begin : result_check
        deq_view_t want;
        deq_view_t got;
        deq_view_t predicted;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{front_value, back_value, item_count, is_empty, status_t'(status)};
                if (awaited_views.size() == 0)
                    log_mismatch('0, got, 1'b1);
                else
                begin
                    want = awaited_views[0];
                    awaited_views.delete(0);
                    if (got.front !== want.front || got.back !== want.back ||
                        got.count !== want.count || got.empty !== want.empty ||
                        got.st !== want.st)
                        log_mismatch(want, got, 1'b0);
                end
            end
            if (start && !busy)
            begin
                predicted = apply_action(action, push_value);
                if (row_is_typed)
                    predicted = row_view;
                awaited_views = {awaited_views, predicted};
            end
            stall_cycles <= (done || (start && !busy)) ? 0 : stall_cycles + 1;
        end
    end

    // Present one request, with random idle cycles ahead of it, until taken
    task automatic send_request(input logic [2:0] act, input logic signed [31:0] val,
                                input bit typed, input deq_view_t exp, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        action       <= act;
        push_value   <= val;
        row_is_typed <= typed;
        row_view     <= exp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending until every outstanding result has come back
    task automatic hold_until_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (awaited_views.size() != 0);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                 seg_left;
        int                 mode;
        int                 push_w;
        int                 r;
        logic [2:0]         act;
        logic signed [31:0] val;
        head_idx     = 0;
        fill_count   = 0;
        view_errors  = 0;
        stall_cycles = 0;
        seg_left     = 0;
        mode         = 0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        action       <= ACT_PEEK;
        push_value   <= '0;
        row_is_typed <= 1'b0;
        row_view     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
            for (int k = 0; k < directed_rows[i].rep; k++)
                send_request(directed_rows[i].act, directed_rows[i].val + k,
                             directed_rows[i].typed, directed_rows[i].exp, 0);
        hold_until_drained();

        // Random segments biased to fill, to drain, or balanced
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n != 0 && n % PHASE_ITEMS == 0)
                hold_until_drained();
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(40, 10);
                mode     = $urandom_range(2);
            end
            seg_left--;
            push_w = (mode == 0) ? 70 : (mode == 1) ? 20 : 42;
            r = $urandom_range(99);
            if (r < push_w)
                act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else if (r < 85)
                act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
            else if (r < 92)
                act = ACT_PEEK;
            else if (r < 97)
                act = $urandom_range(1) ? ACT_NOP_7 : ACT_NOP_6;
            else
                act = ACT_CLEAR;
            case ($urandom_range(7))
                0:       val = VAL_MAX;
                1:       val = VAL_MIN;
                2:       val = '0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase
            send_request(act, val, 1'b0, '0, IDLE_PCT[n / PHASE_ITEMS]);
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (view_errors == 0 && awaited_views.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog on cycles with neither a request nor a result taken
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
